[sv/mtt_pkg.sv]
// shared types, character codes and helpers for the markup tag tokenizer
`default_nettype none

package mtt_pkg;

  // parse phases, one-hot
  typedef enum logic [15:0] {
    PH_PROLOG_OK   = 16'h0001,
    PH_PI_SKIP     = 16'h0002,
    PH_IN_PI       = 16'h0004,
    PH_PI_END_SKIP = 16'h0008,
    PH_OPEN        = 16'h0010,
    PH_START_NAME  = 16'h0020,
    PH_PI_QUOTE    = 16'h0040,
    PH_ATTR_CLOSE  = 16'h0080,
    PH_EMPTY_SKIP  = 16'h0100,
    PH_EQUALS      = 16'h0200,
    PH_VALUE_OPEN  = 16'h0400,
    PH_IN_VALUE    = 16'h0800,
    PH_END_SKIP    = 16'h1000,
    PH_END_NAME    = 16'h2000,
    PH_END_CLOSE   = 16'h4000,
    PH_DONE        = 16'h8000
  } phase_t;

  // event codes
  localparam logic [3:0] EV_START_CHAR  = 4'd0;
  localparam logic [3:0] EV_ATTR_CHAR   = 4'd1;
  localparam logic [3:0] EV_VALUE_CHAR  = 4'd2;
  localparam logic [3:0] EV_END_CHAR    = 4'd3;
  localparam logic [3:0] EV_START_CLOSE = 4'd4;
  localparam logic [3:0] EV_EMPTY_CLOSE = 4'd5;
  localparam logic [3:0] EV_END_CLOSE   = 4'd6;
  localparam logic [3:0] EV_PROLOG      = 4'd7;
  localparam logic [3:0] EV_ERROR       = 4'd8;
  localparam logic [3:0] EV_DONE        = 4'd9;

  // error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_OPENER      = 4'd1;
  localparam logic [3:0] ERR_START_NAME  = 4'd2;
  localparam logic [3:0] ERR_EQUALS      = 4'd3;
  localparam logic [3:0] ERR_VALUE       = 4'd4;
  localparam logic [3:0] ERR_START_CLOSE = 4'd5;
  localparam logic [3:0] ERR_END_NAME    = 4'd6;
  localparam logic [3:0] ERR_END_CLOSE   = 4'd7;
  localparam logic [3:0] ERR_EARLY_END   = 4'd8;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // result queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] char_out;
    logic       token_last;
    logic [3:0] error_code;
  } res_t;

  // results of one input transfer, at most two
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [1:0]      res;
  } rec_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic res_t mk_res(input logic [3:0] ev, input logic [7:0] ch,
                                  input logic last, input logic [3:0] err);
    res_t r;
    r.event_res  = ev;
    r.char_out   = ch;
    r.token_last = last;
    r.error_code = err;
    mk_res = r;
  endfunction

endpackage

`default_nettype wire

[sv/mtt_front.sv]
// front part: takes bytes, keeps lookahead and parse phase, forms result records
`default_nettype none

module mtt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    in_byte,
  input  wire logic          stream_end,
  output mtt_pkg::rec_t      rec,
  output logic               rec_push
);

  mtt_pkg::phase_t phase;
  mtt_pkg::phase_t ph_mid;
  mtt_pkg::phase_t ph_final;
  logic [7:0]      held_byte;
  logic            held_valid;

  logic            end_item;
  logic [7:0]      nb;
  logic [7:0]      c;
  logic            tok_last;
  logic            sp;
  logic            emit0;
  logic            emit1;
  mtt_pkg::res_t   r0;
  mtt_pkg::res_t   r1;

  always_comb begin
    end_item = stream_end | (in_byte == mtt_pkg::CH_NUL);
    nb       = end_item ? mtt_pkg::CH_NUL : in_byte;
    c        = held_byte;
    tok_last = !mtt_pkg::is_letter(nb);
    sp       = mtt_pkg::is_space(c);
    ph_mid   = phase;
    emit0    = 1'b0;
    r0       = '0;

    // interpret the held byte now that its successor is known
    if (held_valid && phase != mtt_pkg::PH_DONE) begin
      case (phase)
        mtt_pkg::PH_PI_SKIP:     ph_mid = mtt_pkg::PH_IN_PI;
        mtt_pkg::PH_PI_END_SKIP: ph_mid = mtt_pkg::PH_OPEN;
        mtt_pkg::PH_EMPTY_SKIP:  ph_mid = mtt_pkg::PH_OPEN;
        mtt_pkg::PH_END_SKIP:    ph_mid = mtt_pkg::PH_END_NAME;
        mtt_pkg::PH_IN_PI: begin
          if (c == mtt_pkg::CH_QUOTE) begin
            ph_mid = mtt_pkg::PH_PI_QUOTE;
          end else if (c == mtt_pkg::CH_QMARK && nb == mtt_pkg::CH_GT) begin
            emit0  = 1'b1;
            r0     = mtt_pkg::mk_res(mtt_pkg::EV_PROLOG, '0, 1'b0, mtt_pkg::ERR_NONE);
            ph_mid = mtt_pkg::PH_PI_END_SKIP;
          end
        end
        mtt_pkg::PH_PI_QUOTE: begin
          if (c == mtt_pkg::CH_QUOTE) ph_mid = mtt_pkg::PH_IN_PI;
        end
        mtt_pkg::PH_IN_VALUE: begin
          if (c == mtt_pkg::CH_QUOTE) begin
            ph_mid = mtt_pkg::PH_ATTR_CLOSE;
          end else begin
            emit0 = 1'b1;
            r0    = mtt_pkg::mk_res(mtt_pkg::EV_VALUE_CHAR, c, nb == mtt_pkg::CH_QUOTE,
                                    mtt_pkg::ERR_NONE);
          end
        end
        mtt_pkg::PH_PROLOG_OK, mtt_pkg::PH_OPEN: begin
          if (!sp) begin
            if (c != mtt_pkg::CH_LT) begin
              emit0  = 1'b1;
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_OPENER);
              ph_mid = mtt_pkg::PH_DONE;
            end else if (nb == mtt_pkg::CH_SLASH) begin
              ph_mid = mtt_pkg::PH_END_SKIP;
            end else if (nb == mtt_pkg::CH_QMARK) begin
              if (phase == mtt_pkg::PH_PROLOG_OK) begin
                ph_mid = mtt_pkg::PH_PI_SKIP;
              end else begin
                // only one prolog, and only before the first tag
                emit0  = 1'b1;
                r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_OPENER);
                ph_mid = mtt_pkg::PH_DONE;
              end
            end else begin
              ph_mid = mtt_pkg::PH_START_NAME;
            end
          end
        end
        mtt_pkg::PH_START_NAME: begin
          if (!sp) begin
            emit0 = 1'b1;
            if (!mtt_pkg::is_letter(c)) begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_START_NAME);
              ph_mid = mtt_pkg::PH_DONE;
            end else begin
              r0 = mtt_pkg::mk_res(mtt_pkg::EV_START_CHAR, c, tok_last, mtt_pkg::ERR_NONE);
              if (tok_last) ph_mid = mtt_pkg::PH_ATTR_CLOSE;
            end
          end
        end
        mtt_pkg::PH_ATTR_CLOSE: begin
          if (!sp) begin
            emit0 = 1'b1;
            if (mtt_pkg::is_letter(c)) begin
              r0 = mtt_pkg::mk_res(mtt_pkg::EV_ATTR_CHAR, c, tok_last, mtt_pkg::ERR_NONE);
              if (tok_last) ph_mid = mtt_pkg::PH_EQUALS;
            end else if (c == mtt_pkg::CH_GT) begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_START_CLOSE, '0, 1'b0, mtt_pkg::ERR_NONE);
              ph_mid = mtt_pkg::PH_OPEN;
            end else if (c == mtt_pkg::CH_SLASH && nb == mtt_pkg::CH_GT) begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_EMPTY_CLOSE, '0, 1'b0, mtt_pkg::ERR_NONE);
              ph_mid = mtt_pkg::PH_EMPTY_SKIP;
            end else begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0,
                                       mtt_pkg::ERR_START_CLOSE);
              ph_mid = mtt_pkg::PH_DONE;
            end
          end
        end
        mtt_pkg::PH_EQUALS: begin
          if (!sp) begin
            if (c == mtt_pkg::CH_EQ) begin
              ph_mid = mtt_pkg::PH_VALUE_OPEN;
            end else begin
              emit0  = 1'b1;
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_EQUALS);
              ph_mid = mtt_pkg::PH_DONE;
            end
          end
        end
        mtt_pkg::PH_VALUE_OPEN: begin
          if (!sp) begin
            if (c == mtt_pkg::CH_QUOTE) begin
              ph_mid = mtt_pkg::PH_IN_VALUE;
            end else begin
              emit0  = 1'b1;
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_VALUE);
              ph_mid = mtt_pkg::PH_DONE;
            end
          end
        end
        mtt_pkg::PH_END_NAME: begin
          if (!sp) begin
            emit0 = 1'b1;
            if (!mtt_pkg::is_letter(c)) begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_END_NAME);
              ph_mid = mtt_pkg::PH_DONE;
            end else begin
              r0 = mtt_pkg::mk_res(mtt_pkg::EV_END_CHAR, c, tok_last, mtt_pkg::ERR_NONE);
              if (tok_last) ph_mid = mtt_pkg::PH_END_CLOSE;
            end
          end
        end
        mtt_pkg::PH_END_CLOSE: begin
          if (!sp) begin
            emit0 = 1'b1;
            if (c == mtt_pkg::CH_GT) begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_END_CLOSE, '0, 1'b0, mtt_pkg::ERR_NONE);
              ph_mid = mtt_pkg::PH_OPEN;
            end else begin
              r0     = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_END_CLOSE);
              ph_mid = mtt_pkg::PH_DONE;
            end
          end
        end
        default: ph_mid = phase;
      endcase
    end

    // end of stream
    ph_final = ph_mid;
    emit1    = 1'b0;
    r1       = '0;
    if (end_item && ph_mid != mtt_pkg::PH_DONE) begin
      emit1    = 1'b1;
      ph_final = mtt_pkg::PH_DONE;
      if (ph_mid == mtt_pkg::PH_PROLOG_OK || ph_mid == mtt_pkg::PH_OPEN) begin
        r1 = mtt_pkg::mk_res(mtt_pkg::EV_DONE, '0, 1'b0, mtt_pkg::ERR_NONE);
      end else begin
        r1 = mtt_pkg::mk_res(mtt_pkg::EV_ERROR, '0, 1'b0, mtt_pkg::ERR_EARLY_END);
      end
    end

    // pack the record, results in order
    rec = '0;
    if (emit0) begin
      rec.res[0] = r0;
      rec.res[1] = r1;
      rec.cnt    = emit1 ? 2'd2 : 2'd1;
    end else if (emit1) begin
      rec.res[0] = r1;
      rec.cnt    = 2'd1;
    end
    rec_push = take && (emit0 || emit1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mtt_pkg::PH_PROLOG_OK;
      held_valid <= 1'b0;
    end else if (take) begin
      phase      <= ph_final;
      held_valid <= !end_item && (ph_mid != mtt_pkg::PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

[sv/mtt_queue.sv]
// short record queue between front and back
`default_nettype none

module mtt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mtt_pkg::rec_t  push_rec,
  input  wire logic           pop,
  output mtt_pkg::rec_t       head,
  output logic                full,
  output logic                empty
);

  mtt_pkg::rec_t                  q [mtt_pkg::QDEPTH];
  logic [mtt_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mtt_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mtt_pkg::QPTR_W:0]       fill;

  assign full  = (fill == (mtt_pkg::QPTR_W+1)'(mtt_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

[sv/mtt_back.sv]
// back part: unpacks records into single results behind an output register
`default_nettype none

module mtt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mtt_pkg::rec_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         event_res,
  output logic [7:0]         char_out,
  output logic               token_last,
  output logic [3:0]         error_code,
  output logic               run_last
);

  mtt_pkg::rec_t cur;
  logic          idx;
  mtt_pkg::res_t res;

  always_comb begin
    res        = cur.res[idx];
    event_res  = res.event_res;
    char_out   = res.char_out;
    token_last = res.token_last;
    error_code = res.error_code;
    run_last   = (cur.cnt == 2'd2) ? idx : 1'b1;
    pop        = !empty && (!out_valid || (out_ready && run_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      idx       <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (run_last) begin
        out_valid <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

`default_nettype wire

[sv/markup_tag_tokenizer.sv]
// markup tag tokenizer: one byte per cycle, results through a queue and output register
// throughput: one byte per cycle unless stalled; results one per cycle while out_ready
// a byte's results depend on its successor, so they are formed when the next byte
// (or end of stream) is taken, enter the queue at that transfer and pass from there
// into the output register once it is free
// input stalls only when the four-record queue is full
// reset (rst, synchronous) returns to prolog-allowed, drops lookahead and pending results
`default_nettype none

module markup_tag_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        stream_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       event_res,
  output logic [7:0]       char_out,
  output logic             token_last,
  output logic [3:0]       error_code,
  output logic             run_last
);

  // front to queue
  mtt_pkg::rec_t rec;
  logic          rec_push;
  logic          take;

  // queue to back
  mtt_pkg::rec_t head;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  // take a byte whenever a record slot is free; bytes giving no result still flow
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // lookahead, parse phase and result classification
  mtt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .rec        (rec),
    .rec_push   (rec_push)
  );

  // decouples the parser from output stalls
  mtt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // one result per output transfer, run_last on the final one of a record
  mtt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .char_out   (char_out),
    .token_last (token_last),
    .error_code (error_code),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire
